// ===== sv/iwae_pkg.sv =====
// shared codes, widths and types of the indexed word array engine
package iwae_pkg;

  localparam int IDX_W         = 10;
  localparam int DATA_W        = 64;
  localparam int POS_W         = 10;
  localparam int CNT_OUT_W     = 11;
  localparam int OP_W          = 3;
  localparam int ST_W          = 2;
  localparam int ACT_W         = 3;

  localparam int DEF_CAPACITY  = 1024;
  localparam int DEF_WORD_BITS = 64;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_READ   = 3'd2;
  localparam logic [OP_W-1:0] OP_XCHG   = 3'd3;
  localparam logic [OP_W-1:0] OP_POP    = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE  = 2'd2;
  localparam logic [ST_W-1:0] ST_RDONLY = 2'd3;

  // what the back end does with a queued job
  localparam logic [ACT_W-1:0] ACT_NONE  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUT   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SHIFT = 3'd2;
  localparam logic [ACT_W-1:0] ACT_READ  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_XCHG  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_POP   = 3'd5;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [ST_W-1:0]  status;
  } job_ctl_t;

endpackage

// ===== sv/iwae_front.sv =====
// front end: takes commands and config, checks them against the fill count, queues jobs
module iwae_front #(
  parameter int CAPACITY  = iwae_pkg::DEF_CAPACITY,
  parameter int WORD_BITS = iwae_pkg::DEF_WORD_BITS,
  parameter int AW        = $clog2(CAPACITY),
  parameter int CW        = $clog2(CAPACITY + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          q_full,
  input  logic [iwae_pkg::OP_W-1:0]     in_operation,
  input  logic [iwae_pkg::IDX_W-1:0]    in_index,
  input  logic [iwae_pkg::DATA_W-1:0]   in_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_read_only,
  output logic                          cfg_ready,
  output logic                          busy,
  output logic                          push,
  output iwae_pkg::job_ctl_t            job_ctl,
  output logic [AW-1:0]                 job_addr,
  output logic [CW-1:0]                 job_cnt,
  output logic [WORD_BITS-1:0]          job_data
);

  localparam int CMPW = (CW > iwae_pkg::IDX_W) ? CW : iwae_pkg::IDX_W;

  logic [CW-1:0]   count_r, count_nxt;
  logic            read_only_r;
  logic [CMPW-1:0] idx_c, cnt_c, tgt_c;
  logic            full_c, empty_c;

  assign cfg_ready = 1'b1;
  assign busy      = q_full;
  assign push      = start && !q_full;

  assign idx_c   = CMPW'(in_index);
  assign cnt_c   = CMPW'(count_r);
  assign tgt_c   = (in_operation == iwae_pkg::OP_APPEND) ? cnt_c : idx_c;
  assign full_c  = (count_r == CW'(CAPACITY));
  assign empty_c = (count_r == '0);

  always_comb begin
    count_nxt      = count_r;
    job_ctl.action = iwae_pkg::ACT_NONE;
    job_ctl.status = iwae_pkg::ST_OK;
    job_addr       = '0;
    unique case (in_operation)
      iwae_pkg::OP_APPEND, iwae_pkg::OP_INSERT: begin
        if (read_only_r) begin
          job_ctl.status = iwae_pkg::ST_RDONLY;
        end else if (tgt_c > cnt_c) begin
          job_ctl.status = iwae_pkg::ST_RANGE;
        end else if (full_c) begin
          job_ctl.status = iwae_pkg::ST_FULL;
        end else begin
          count_nxt      = count_r + CW'(1);
          job_addr       = AW'(tgt_c);
          job_ctl.action = (tgt_c == cnt_c) ? iwae_pkg::ACT_PUT : iwae_pkg::ACT_SHIFT;
        end
      end
      iwae_pkg::OP_READ: begin
        if (idx_c >= cnt_c) begin
          job_ctl.status = iwae_pkg::ST_RANGE;
        end else begin
          job_addr       = AW'(idx_c);
          job_ctl.action = iwae_pkg::ACT_READ;
        end
      end
      iwae_pkg::OP_XCHG: begin
        if (read_only_r) begin
          job_ctl.status = iwae_pkg::ST_RDONLY;
        end else if (idx_c >= cnt_c) begin
          job_ctl.status = iwae_pkg::ST_RANGE;
        end else begin
          job_addr       = AW'(idx_c);
          job_ctl.action = iwae_pkg::ACT_XCHG;
        end
      end
      iwae_pkg::OP_POP: begin
        if (read_only_r) begin
          job_ctl.status = iwae_pkg::ST_RDONLY;
        end else if (empty_c) begin
          job_ctl.status = iwae_pkg::ST_RANGE;
        end else begin
          count_nxt      = count_r - CW'(1);
          job_addr       = AW'(count_nxt);
          job_ctl.action = iwae_pkg::ACT_POP;
        end
      end
      iwae_pkg::OP_CLEAR: begin
        if (empty_c) begin
          job_ctl.status = iwae_pkg::ST_RANGE;
        end else begin
          count_nxt = '0;
        end
      end
      default: begin
        job_ctl.status = iwae_pkg::ST_RANGE;
      end
    endcase
  end

  assign job_cnt  = count_nxt;
  assign job_data = in_data[WORD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      read_only_r <= 1'b0;
    end else begin
      if (push) begin
        count_r <= count_nxt;
      end
      if (cfg_valid) begin
        read_only_r <= cfg_read_only;
      end
    end
  end

endmodule

// ===== sv/iwae_queue.sv =====
// short job queue between front and back end
module iwae_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data,
  output logic             full
);

  localparam int DEPTH = iwae_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [LW-1:0]    level_r;

  assign head_valid = (level_r != '0);
  assign full       = (level_r == LW'(DEPTH));
  assign head_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        level_r <= level_r + LW'(1);
      end else if (pop && !push) begin
        level_r <= level_r - LW'(1);
      end
    end
  end

endmodule

// ===== sv/iwae_back.sv =====
// back end: word memory, shift sequencer and result registers
module iwae_back #(
  parameter int CAPACITY  = iwae_pkg::DEF_CAPACITY,
  parameter int WORD_BITS = iwae_pkg::DEF_WORD_BITS,
  parameter int AW        = $clog2(CAPACITY),
  parameter int CW        = $clog2(CAPACITY + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            head_valid,
  input  iwae_pkg::job_ctl_t              head_ctl,
  input  logic [AW-1:0]                   head_addr,
  input  logic [CW-1:0]                   head_cnt,
  input  logic [WORD_BITS-1:0]            head_data,
  output logic                            pop,
  output logic                            out_valid,
  output logic [iwae_pkg::ST_W-1:0]       out_status,
  output logic [iwae_pkg::DATA_W-1:0]     out_read_value,
  output logic [iwae_pkg::POS_W-1:0]      out_position,
  output logic [iwae_pkg::CNT_OUT_W-1:0]  out_entry_count,
  output logic                            out_is_empty
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WAIT  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [WORD_BITS-1:0] mem [CAPACITY];
  logic [WORD_BITS-1:0] rdata_r;

  logic [1:0]           state_r, state_nxt;
  iwae_pkg::job_ctl_t   job_ctl_r;
  logic [AW-1:0]        job_addr_r;
  logic [CW-1:0]        job_cnt_r;
  logic [WORD_BITS-1:0] job_data_r;
  logic [AW-1:0]        ptr_r, ptr_nxt;

  logic                 we, re, emit;
  logic [AW-1:0]        waddr, raddr;
  logic [WORD_BITS-1:0] wdata;

  iwae_pkg::job_ctl_t   src_ctl;
  logic [AW-1:0]        src_addr;
  logic [CW-1:0]        src_cnt;
  logic [WORD_BITS-1:0] src_rval;

  logic                          out_valid_r;
  logic [iwae_pkg::ST_W-1:0]     out_status_r;
  logic [iwae_pkg::DATA_W-1:0]   out_read_value_r;
  logic [iwae_pkg::POS_W-1:0]    out_position_r;
  logic [iwae_pkg::CNT_OUT_W-1:0] out_entry_count_r;
  logic                          out_is_empty_r;

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    pop       = 1'b0;
    we        = 1'b0;
    re        = 1'b0;
    emit      = 1'b0;
    waddr     = head_addr;
    raddr     = head_addr;
    wdata     = head_data;
    src_ctl   = job_ctl_r;
    src_addr  = job_addr_r;
    src_cnt   = job_cnt_r;
    src_rval  = '0;
    unique case (state_r)
      S_IDLE: begin
        src_ctl  = head_ctl;
        src_addr = head_addr;
        src_cnt  = head_cnt;
        if (head_valid) begin
          pop = 1'b1;
          unique case (head_ctl.action)
            iwae_pkg::ACT_PUT: begin
              we   = 1'b1;
              emit = 1'b1;
            end
            iwae_pkg::ACT_SHIFT: begin
              // last live entry before the insert sits at new count minus two
              re        = 1'b1;
              raddr     = AW'(head_cnt - CW'(2));
              ptr_nxt   = raddr;
              state_nxt = S_SHIFT;
            end
            iwae_pkg::ACT_READ, iwae_pkg::ACT_XCHG, iwae_pkg::ACT_POP: begin
              re        = 1'b1;
              state_nxt = S_WAIT;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_WAIT: begin
        emit      = 1'b1;
        src_rval  = rdata_r;
        waddr     = job_addr_r;
        wdata     = (job_ctl_r.action == iwae_pkg::ACT_POP) ? '0 : job_data_r;
        we        = (job_ctl_r.action != iwae_pkg::ACT_READ);
        state_nxt = S_IDLE;
      end
      S_SHIFT: begin
        // move the word read last cycle up one place, fetch the one below unless at the insert position
        we    = 1'b1;
        waddr = ptr_r + AW'(1);
        wdata = rdata_r;
        if (ptr_r == job_addr_r) begin
          state_nxt = S_FIN;
        end else begin
          re      = 1'b1;
          raddr   = ptr_r - AW'(1);
          ptr_nxt = raddr;
        end
      end
      S_FIN: begin
        we        = 1'b1;
        waddr     = job_addr_r;
        wdata     = job_data_r;
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_ctl_r  <= head_ctl;
      job_addr_r <= head_addr;
      job_cnt_r  <= head_cnt;
      job_data_r <= head_data;
    end
    ptr_r <= ptr_nxt;
    if (emit) begin
      out_status_r      <= src_ctl.status;
      out_read_value_r  <= iwae_pkg::DATA_W'(src_rval);
      out_position_r    <= (src_ctl.action == iwae_pkg::ACT_PUT ||
                            src_ctl.action == iwae_pkg::ACT_SHIFT) ?
                           iwae_pkg::POS_W'(src_addr) : '0;
      out_entry_count_r <= iwae_pkg::CNT_OUT_W'(src_cnt);
      out_is_empty_r    <= (src_cnt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_read_value_r;
  assign out_position    = out_position_r;
  assign out_entry_count = out_entry_count_r;
  assign out_is_empty    = out_is_empty_r;

  a_shift_job: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT |-> job_ctl_r.action == iwae_pkg::ACT_SHIFT)
    else $error("shift sequencer running on a job that is not a shifting insert");

  a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT |-> ptr_r >= job_addr_r)
    else $error("shift pointer moved below the insert position");

  a_fin_emits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN |=> out_valid_r)
    else $error("insert finished without a result");

  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != iwae_pkg::ST_OK |->
      out_read_value_r == '0 && out_position_r == '0)
    else $error("failed command returned a word or a position");

endmodule

// ===== sv/indexed_word_array_engine.sv =====
// top level of the indexed word array engine: front end, job queue, back end
//
//  channel   ports                                   transfer when
//  command   start, busy, in_operation/index/data    start && !busy
//  result    out_valid, out_status ... out_is_empty  out_valid (one cycle)
//  config    cfg_valid, cfg_ready, cfg_read_only     cfg_valid && cfg_ready
//
//  the front end checks a command against its fill count in the cycle it arrives and
//  queues it; busy is high while the two-entry job queue is full
//  back end per job: append, insert at the count, clear and refused commands are done
//  straight from idle; read, exchange and pop do a registered memory read, then exchange
//  and pop write; insert before index i below the count n: one entry moved per cycle
//  reset clears the fill count, read-only flag, queue and sequencer; the word memory
//  is not cleared and needs no sweep
//  results are never held off: each appears for one cycle with out_valid
module indexed_word_array_engine #(
  parameter int CAPACITY  = iwae_pkg::DEF_CAPACITY,
  parameter int WORD_BITS = iwae_pkg::DEF_WORD_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [iwae_pkg::OP_W-1:0]       in_operation,
  input  logic [iwae_pkg::IDX_W-1:0]      in_index,
  input  logic [iwae_pkg::DATA_W-1:0]     in_data,
  output logic                            out_valid,
  output logic [iwae_pkg::ST_W-1:0]       out_status,
  output logic [iwae_pkg::DATA_W-1:0]     out_read_value,
  output logic [iwae_pkg::POS_W-1:0]      out_position,
  output logic [iwae_pkg::CNT_OUT_W-1:0]  out_entry_count,
  output logic                            out_is_empty,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_read_only
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int CTL_W = $bits(iwae_pkg::job_ctl_t);
  localparam int JOB_W = CTL_W + AW + CW + WORD_BITS;

  logic                 push, pop, q_full, head_valid;
  iwae_pkg::job_ctl_t   f_ctl, h_ctl;
  logic [AW-1:0]        f_addr, h_addr;
  logic [CW-1:0]        f_cnt, h_cnt;
  logic [WORD_BITS-1:0] f_data, h_data;
  logic [JOB_W-1:0]     q_in, q_head;

  iwae_front #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS),
    .AW        (AW),
    .CW        (CW)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .q_full        (q_full),
    .in_operation  (in_operation),
    .in_index      (in_index),
    .in_data       (in_data),
    .cfg_valid     (cfg_valid),
    .cfg_read_only (cfg_read_only),
    .cfg_ready     (cfg_ready),
    .busy          (busy),
    .push          (push),
    .job_ctl       (f_ctl),
    .job_addr      (f_addr),
    .job_cnt       (f_cnt),
    .job_data      (f_data)
  );

  assign q_in = {f_ctl, f_addr, f_cnt, f_data};

  iwae_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (q_in),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (q_head),
    .full       (q_full)
  );

  assign {h_ctl, h_addr, h_cnt, h_data} = q_head;

  iwae_back #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS),
    .AW        (AW),
    .CW        (CW)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_ctl        (h_ctl),
    .head_addr       (h_addr),
    .head_cnt        (h_cnt),
    .head_data       (h_data),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_position    (out_position),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty)
  );

endmodule
